@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a plain property, disabled while reset is low.
`define SMOU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication built on the plain form.
`define SMOU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `SMOU_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication built on the plain form.
`define SMOU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  `SMOU_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ hw/rtl/smou_pkg.sv @@
// Package of the square matrix operation unit: sizes, mode codes and structs.
// Depends on nothing; every module of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package smou_pkg;

  // Matrix dimension and derived widths.
  localparam int unsigned DIM     = 5;
  localparam int unsigned COORD_W = 3;
  localparam int unsigned IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned DATA_W  = 32;

  // Operation codes carried by the mode field.
  typedef enum logic [2:0] {
    MODE_LOAD_A  = 3'd0,
    MODE_LOAD_B  = 3'd1,
    MODE_ADD     = 3'd2,
    MODE_MUL     = 3'd3,
    MODE_TRANS_A = 3'd4,
    MODE_TRANS_B = 3'd5,
    MODE_READ_A  = 3'd6,
    MODE_READ_B  = 3'd7
  } mode_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ISSUE,
    SEQ_DRAIN
  } seq_state_e;

  // One result element travelling down the chain of cells.
  typedef struct packed {
    logic               valid;
    mode_e              mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } token_t;

  // Element write broadcast to all cells.
  typedef struct packed {
    logic               load_a;
    logic               load_b;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  value;
  } load_t;

  // Pipeline status seen by the sequencer.
  typedef struct packed {
    logic advance;
    logic chain_empty;
    logic out_busy;
  } seq_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/smou_cell.sv @@
// One cell of the chain: holds column k of A and row k of B, adds its term
// to the running partial sum. Depends on smou_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smou_cell
  import smou_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COORD_W-1:0] cell_idx_i,
  input  wire logic               advance_i,
  input  wire load_t              load_i,
  input  wire token_t             tok_i,
  input  wire logic [DATA_W-1:0]  psum_i,
  output token_t                  tok_o,
  output logic      [DATA_W-1:0]  sum_o
);

  // Local element stores, no reset.
  logic [DATA_W-1:0] a_col_q [DIM];
  logic [DATA_W-1:0] b_row_q [DIM];

  logic               tok_valid_q;
  mode_e              tok_mode_q;
  logic [COORD_W-1:0] tok_row_q;
  logic [COORD_W-1:0] tok_col_q;
  logic [DATA_W-1:0] psum_q;
  logic [DATA_W-1:0] term_q;
  logic [DATA_W-1:0] term_d;
  logic [COORD_W-1:0] a_sel;
  logic [COORD_W-1:0] b_sel;
  logic [DATA_W-1:0] a_val;
  logic [DATA_W-1:0] b_val;
  logic              hit_row;
  logic              hit_col;

  // Element writes that land in this cell.
  always_ff @(posedge clk_i) begin
    if (load_i.load_a && load_i.col == cell_idx_i) begin
      a_col_q[load_i.row[IDX_W-1:0]] <= load_i.value;
    end
    if (load_i.load_b && load_i.row == cell_idx_i) begin
      b_row_q[load_i.col[IDX_W-1:0]] <= load_i.value;
    end
  end

  // Pick the local A and B elements that this token needs.
  always_comb begin
    a_sel   = (tok_i.mode == MODE_TRANS_A) ? tok_i.col : tok_i.row;
    b_sel   = (tok_i.mode == MODE_TRANS_B) ? tok_i.row : tok_i.col;
    a_val   = a_col_q[a_sel[IDX_W-1:0]];
    b_val   = b_row_q[b_sel[IDX_W-1:0]];
    hit_row = (tok_i.row == cell_idx_i);
    hit_col = (tok_i.col == cell_idx_i);
  end

  // The contribution of this cell to the element.
  always_comb begin
    unique case (tok_i.mode)
      MODE_MUL:     term_d = DATA_W'(a_val * b_val);
      MODE_ADD:     term_d = (hit_col ? a_val : '0) + (hit_row ? b_val : '0);
      MODE_READ_A:  term_d = hit_col ? a_val : '0;
      MODE_TRANS_A: term_d = hit_row ? a_val : '0;
      MODE_READ_B:  term_d = hit_row ? b_val : '0;
      MODE_TRANS_B: term_d = hit_col ? b_val : '0;
      default:      term_d = '0;
    endcase
  end

  // Stage register: the token valid bit resets; mode, coordinates and data do not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else if (advance_i) begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tok_mode_q <= tok_i.mode;
      tok_row_q  <= tok_i.row;
      tok_col_q  <= tok_i.col;
      psum_q     <= psum_i;
      term_q     <= term_d;
    end
  end

  always_comb begin
    tok_o.valid = tok_valid_q;
    tok_o.mode  = tok_mode_q;
    tok_o.row   = tok_row_q;
    tok_o.col   = tok_col_q;
  end

  assign sum_o = psum_q + term_q;

endmodule

`default_nettype wire

@@ hw/rtl/smou_seq.sv @@
// Command sequencer: takes input beats and walks a result matrix in
// row-major order into the chain. Depends on smou_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smou_seq
  import smou_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire mode_e       mode_i,
  input  wire seq_status_t status_i,
  output logic             in_ready_o,
  output token_t           tok_o
);

  seq_state_e         state_q, state_d;
  mode_e              mode_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic               is_cmd;
  logic               at_end;

  assign is_cmd = (mode_i != MODE_LOAD_A) && (mode_i != MODE_LOAD_B);
  assign at_end = (row_q == COORD_W'(DIM - 1)) && (col_q == COORD_W'(DIM - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i && is_cmd) begin
          state_d = SEQ_ISSUE;
        end
      end
      SEQ_ISSUE: begin
        if (status_i.advance && at_end) begin
          state_d = SEQ_DRAIN;
        end
      end
      SEQ_DRAIN: begin
        if (status_i.chain_empty && !status_i.out_busy) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = (state_q == SEQ_IDLE);
    tok_o.valid = (state_q == SEQ_ISSUE);
    tok_o.mode  = mode_q;
    tok_o.row   = row_q;
    tok_o.col   = col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command latch and row-major coordinate counters.
  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_IDLE) begin
      mode_q <= mode_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (state_q == SEQ_ISSUE && status_i.advance) begin
      if (col_q == COORD_W'(DIM - 1)) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/square_matrix_operation_unit.sv @@
// A command's results pass through the chain of cells and the output register, then leave one
// element per cycle while out_ready_i stays high. A command holds the input until its last result
// has left the output register: one token enters the chain of DIM cells per cycle while the
// output does not stall, and each cell adds one term (one multiply in MUL mode) per element.
// Reset clears control state only; matrix contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module square_matrix_operation_unit
  import smou_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          mode_i,
  input  wire logic [COORD_W-1:0]  row_i,
  input  wire logic [COORD_W-1:0]  col_i,
  input  wire logic signed [31:0]  value_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [COORD_W-1:0]       out_row_o,
  output logic [COORD_W-1:0]       out_col_o,
  output logic signed [31:0]       out_value_o,
  output logic                     last_o
);

  mode_e             mode;
  logic              in_range;
  logic              accept;
  logic              advance;
  load_t             load;
  seq_status_t       status;
  token_t            seq_tok;
  token_t            tok_w [DIM];
  logic [DATA_W-1:0] sum_w [DIM];
  logic [DIM-1:0]    busy_w;
  logic              out_valid_q;

  assign mode     = mode_e'(mode_i);
  assign in_range = ({1'b0, row_i} < (COORD_W + 1)'(DIM))
                 && ({1'b0, col_i} < (COORD_W + 1)'(DIM));
  assign accept   = in_valid_i && in_ready_o;
  assign advance  = !out_valid_q || out_ready_i;

  // Element write broadcast.
  always_comb begin
    load.load_a = accept && in_range && (mode == MODE_LOAD_A);
    load.load_b = accept && in_range && (mode == MODE_LOAD_B);
    load.row    = row_i;
    load.col    = col_i;
    load.value  = value_i;
  end

  always_comb begin
    status.advance     = advance;
    status.chain_empty = (busy_w == '0);
    status.out_busy    = out_valid_q;
  end

  smou_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .tok_o      (seq_tok)
  );

  // Chain of cells; the partial sum runs from cell 0 to cell DIM-1.
  for (genvar k = 0; k < DIM; k++) begin : g_cell
    token_t            tok_in;
    logic [DATA_W-1:0] psum_in;
    if (k == 0) begin : g_head
      assign tok_in  = seq_tok;
      assign psum_in = '0;
    end else begin : g_body
      assign tok_in  = tok_w[k-1];
      assign psum_in = sum_w[k-1];
    end
    smou_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (COORD_W'(k)),
      .advance_i  (advance),
      .load_i     (load),
      .tok_i      (tok_in),
      .psum_i     (psum_in),
      .tok_o      (tok_w[k]),
      .sum_o      (sum_w[k])
    );
    assign busy_w[k] = tok_w[k].valid;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= tok_w[DIM-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_row_o   <= tok_w[DIM-1].row;
      out_col_o   <= tok_w[DIM-1].col;
      out_value_o <= sum_w[DIM-1];
      last_o      <= (tok_w[DIM-1].row == COORD_W'(DIM - 1))
                  && (tok_w[DIM-1].col == COORD_W'(DIM - 1));
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/smou_checker.sv @@
// Port-level checker for the square matrix operation unit, bound to the top.
// Depends on smou_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module smou_checker
  import smou_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic [2:0]          mode_i,
  input wire logic [COORD_W-1:0]  row_i,
  input wire logic [COORD_W-1:0]  col_i,
  input wire logic signed [31:0]  value_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [COORD_W-1:0]  out_row_o,
  input wire logic [COORD_W-1:0]  out_col_o,
  input wire logic signed [31:0]  out_value_o,
  input wire logic                last_o
);

  logic corner;
  assign corner = (out_row_o == COORD_W'(DIM - 1)) && (out_col_o == COORD_W'(DIM - 1));

  // A stalled input beat stays offered with its payload unchanged.
  `SMOU_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable({mode_i, row_i, col_i, value_i}))

  // A stalled result beat stays offered with its payload unchanged.
  `SMOU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable({out_row_o, out_col_o, out_value_o, last_o}))

  // The unit takes no input while results are still pending.
  `SMOU_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_o)

  // The last flag marks exactly the bottom-right element.
  `SMOU_ASSERT_IMP(a_last_corner, clk_i, rst_ni, out_valid_o, last_o == corner)

  // After the last beat of a matrix is taken, the output goes empty.
  `SMOU_ASSERT_NXT(a_last_frees, clk_i, rst_ni, out_valid_o && out_ready_i && last_o,
                   !out_valid_o)

endmodule

bind square_matrix_operation_unit smou_checker u_smou_checker (.*);

`default_nettype wire
